FILE: design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the script token scanner
// token kinds, scan modes, keyword table and character classes
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int KEYWORD_BUFFER_CHARS_DEF = 8;
  localparam int OFFSET_BITS_DEF          = 24;
  localparam int NUM_KEYWORDS             = 16;
  localparam int KEYWORD_MAX              = 8;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_EQUAL  = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS   = 6'd17;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_ERROR  = 6'd38;
  localparam logic [5:0] K_EOF    = 6'd39;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_OP2, M_IDENT,
    M_NUMBER, M_NUMDOT, M_FRACTION, M_STRING
  } scan_mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [23:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } token_t;

  typedef logic [KEYWORD_MAX-1:0][7:0] kw_text_t;

  function automatic kw_text_t kw_text(input int i);
    kw_text_t t;
    t = '0;
    case (i)
      0:  t = {"\0\0\0\0\0dna"};
      1:  t = {"\0\0\0ssalc"};
      2:  t = {"\0\0\0\0esle"};
      3:  t = {"\0\0\0eslaf"};
      4:  t = {"\0\0\0\0\0rof"};
      5:  t = {"noitcnuf"};
      6:  t = {"\0\0\0\0\0\0fi"};
      7:  t = {"\0\0\0\0llun"};
      8:  t = {"\0\0\0\0\0\0ro"};
      9:  t = {"\0\0\0tnirp"};
      10: t = {"\0\0nruter"};
      11: t = {"\0\0\0repus"};
      12: t = {"\0\0\0\0siht"};
      13: t = {"\0\0\0\0eurt"};
      14: t = {"\0\0\0\0\0rav"};
      15: t = {"\0\0\0elihw"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    logic [3:0] l;
    case (i)
      0, 4, 14:                   l = 4'd3;
      1, 3, 9, 11, 15:            l = 4'd5;
      2, 7, 12, 13:               l = 4'd4;
      5:                          l = 4'd8;
      6, 8:                       l = 4'd2;
      10:                         l = 4'd6;
      default:                    l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [5:0] op_base(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "!":     k = K_BANG;
      "=":     k = K_EQUAL;
      ">":     k = K_GREATER;
      default: k = K_LESS;
    endcase
    return k;
  endfunction

endpackage

FILE: design/script_token_scanner_core.sv
// ----------------------------------------------------------------------------
// script_token_scanner_core: character-at-a-time lexical scanner
// takes one character per word, emits tokens with kind, offset, length, line
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | char_byte, end_of_text
// out     | output    | out_valid/out_stall| token_kind .. last_of_run
//
// one input word is taken per cycle while the result queue holds at most one
// token; a word makes zero to three tokens, which leave one per cycle while out is not stalled.
// the four-entry result queue sets the rate: a word making several tokens
// holds input off until the queue has drained back to at most one token.
// rst clears scan state, position, line count and the queue.
// stalls on out back up into in_stall through the queue fill.
// ----------------------------------------------------------------------------
module script_token_scanner_core #(
  parameter int KEYWORD_BUFFER_CHARS = sts_pkg::KEYWORD_BUFFER_CHARS_DEF,
  parameter int OFFSET_BITS          = sts_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [1:0]  error_code,
  output logic [23:0] start_offset,
  output logic [15:0] token_length,
  output logic [15:0] line_number,
  output logic        last_of_run
);
  import sts_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int WB = $clog2(KEYWORD_BUFFER_CHARS);

  scan_mode_t    mode, mode_next;
  logic [7:0]    pend, pend_next;
  logic [OB-1:0] tstart, tstart_next;
  logic [OB-1:0] pos, pos_next;
  logic [15:0]   line, line_next;
  logic [3:0]    wlen, wlen_next;
  logic [7:0]    wbuf [KEYWORD_BUFFER_CHARS];
  logic          wr_en;
  logic [WB-1:0] wr_idx;

  token_t        q [4];
  logic [1:0]    rd, wr;
  logic [2:0]    count;
  token_t        res [3];
  logic [1:0]    n;

  logic accept, pop;

  assign in_stall  = (count > 3'd1);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;

  assign token_kind   = q[rd].kind;
  assign error_code   = q[rd].err;
  assign start_offset = q[rd].start;
  assign token_length = q[rd].len;
  assign line_number  = q[rd].line;
  assign last_of_run  = q[rd].last;

  function automatic logic [15:0] span(input logic [OB-1:0] from, input logic [OB:0] to);
    logic [OB:0] d;
    d = to - {1'b0, from};
    if (to < {1'b0, from}) return 16'd0;
    if (d > (OB+1)'(65535)) return 16'hffff;
    return 16'(d);
  endfunction

  function automatic token_t mk(input logic [5:0] k, input logic [1:0] e,
                                input logic [OB-1:0] s, input logic [15:0] l,
                                input logic [15:0] ln);
    token_t t;
    t.kind  = k;
    t.err   = e;
    t.start = 24'(s);
    t.len   = l;
    t.line  = ln;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic logic [5:0] word_kind(input logic [3:0] len,
                                           input logic [KEYWORD_MAX-1:0][7:0] b);
    logic [5:0] k;
    logic       m;
    kw_text_t   t;
    k = K_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      t = kw_text(i);
      m = (kw_len(i) == len);
      for (int j = 0; j < KEYWORD_MAX; j++) begin
        if (j < int'(kw_len(i)) && b[j] != t[j]) m = 1'b0;
      end
      if (m) k = K_IDENT + 6'd3 + 6'(i);
    end
    return k;
  endfunction

  logic [KEYWORD_MAX-1:0][7:0] wview;
  always_comb begin
    for (int j = 0; j < KEYWORD_MAX; j++) wview[j] = wbuf[j];
  end

  always_comb begin
    logic       fresh;
    logic       do_flush;
    logic [15:0] ln;
    logic [OB:0] p1;
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    n = 2'd0;
    fresh = 1'b0;
    do_flush = 1'b0;
    ln = line;
    p1 = {1'b0, pos};
    mode_next = mode;
    pend_next = pend;
    tstart_next = tstart;
    line_next = line;
    wlen_next = wlen;
    wr_en = 1'b0;
    wr_idx = '0;
    pos_next = (pos != {OB{1'b1}}) ? pos + OB'(1) : pos;

    if (end_of_text) begin
      do_flush = 1'b1;
    end else begin
      case (mode)
        M_SLASH: begin
          if (char_byte == "/") mode_next = M_COMMENT;
          else begin do_flush = 1'b1; fresh = 1'b1; end
        end
        M_COMMENT: begin
          if (char_byte == "\n") fresh = 1'b1;
        end
        M_OP2: begin
          if (char_byte == "=") begin
            res[n] = mk(op_base(pend) + 6'd1, ERR_NONE, tstart, 16'd2, ln);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin do_flush = 1'b1; fresh = 1'b1; end
        end
        M_IDENT: begin
          if (is_alpha(char_byte) || is_digit(char_byte)) begin
            if (32'(wlen) < KEYWORD_BUFFER_CHARS) begin
              wr_en = 1'b1;
              wr_idx = WB'(wlen);
            end
            if (wlen != 4'd15) wlen_next = wlen + 4'd1;
          end else begin do_flush = 1'b1; fresh = 1'b1; end
        end
        M_NUMBER: begin
          if (char_byte == ".") mode_next = M_NUMDOT;
          else if (!is_digit(char_byte)) begin do_flush = 1'b1; fresh = 1'b1; end
        end
        M_NUMDOT: begin
          if (is_digit(char_byte)) mode_next = M_FRACTION;
          else begin do_flush = 1'b1; fresh = 1'b1; end
        end
        M_FRACTION: begin
          if (!is_digit(char_byte)) begin do_flush = 1'b1; fresh = 1'b1; end
        end
        M_STRING: begin
          if (char_byte == "\"" || char_byte == "'") begin
            res[n] = mk(K_STRING, ERR_NONE, tstart, span(tstart, p1 + (OB+1)'(1)), ln);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (char_byte == "\n") begin
            if (line != 16'hffff) line_next = line + 16'd1;
          end
        end
        default: fresh = 1'b1;
      endcase
    end

    if (do_flush) begin
      mode_next = M_IDLE;
      case (mode)
        M_SLASH: begin
          res[n] = mk(K_SLASH, ERR_NONE, tstart, 16'd1, ln);
          n = n + 2'd1;
        end
        M_OP2: begin
          res[n] = mk(op_base(pend), ERR_NONE, tstart, 16'd1, ln);
          n = n + 2'd1;
        end
        M_IDENT: begin
          res[n] = mk(word_kind(wlen, wview), ERR_NONE, tstart, span(tstart, p1), ln);
          n = n + 2'd1;
        end
        M_NUMBER, M_FRACTION: begin
          res[n] = mk(K_NUMBER, ERR_NONE, tstart, span(tstart, p1), ln);
          n = n + 2'd1;
        end
        M_NUMDOT: begin
          res[n] = mk(K_NUMBER, ERR_NONE, tstart, span(tstart, p1 - (OB+1)'(1)), ln);
          n = n + 2'd1;
          res[n] = mk(K_DOT, ERR_NONE, pos - OB'(1), 16'd1, ln);
          n = n + 2'd1;
        end
        M_STRING: begin
          res[n] = mk(K_ERROR, ERR_UNTERM, tstart, span(tstart, p1), ln);
          n = n + 2'd1;
        end
        default: ;
      endcase
    end

    if (end_of_text) begin
      res[n] = mk(K_EOF, ERR_NONE, pos, 16'd0, ln);
      n = n + 2'd1;
      mode_next = M_IDLE;
      pend_next = 8'd0;
      tstart_next = '0;
      pos_next = '0;
      line_next = 16'd1;
      wlen_next = 4'd0;
    end else if (fresh) begin
      mode_next = M_IDLE;
      tstart_next = pos;
      case (char_byte)
        " ", "\r", "\t": ;
        "\n": if (line != 16'hffff) line_next = line + 16'd1;
        "(": begin res[n] = mk(K_LPAREN, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        ")": begin res[n] = mk(K_RPAREN, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        "{": begin res[n] = mk(K_LBRACE, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        "}": begin res[n] = mk(K_RBRACE, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        ",": begin res[n] = mk(K_COMMA, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        ".": begin res[n] = mk(K_DOT, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        "-": begin res[n] = mk(K_MINUS, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        "+": begin res[n] = mk(K_PLUS, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        ";": begin res[n] = mk(K_SEMI, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        "*": begin res[n] = mk(K_STAR, ERR_NONE, pos, 16'd1, ln); n = n + 2'd1; end
        "/": mode_next = M_SLASH;
        "!", "=", ">", "<": begin
          pend_next = char_byte;
          mode_next = M_OP2;
        end
        "\"", "'": mode_next = M_STRING;
        default: begin
          if (is_alpha(char_byte)) begin
            wr_en = 1'b1;
            wr_idx = '0;
            wlen_next = 4'd1;
            mode_next = M_IDENT;
          end else if (is_digit(char_byte)) begin
            mode_next = M_NUMBER;
          end else begin
            res[n] = mk(K_ERROR, ERR_UNEXPECTED, pos, 16'd1, ln);
            n = n + 2'd1;
          end
        end
      endcase
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pend   <= 8'd0;
      tstart <= '0;
      pos    <= '0;
      line   <= 16'd1;
      wlen   <= 4'd0;
    end else if (accept) begin
      mode   <= mode_next;
      pend   <= pend_next;
      tstart <= tstart_next;
      pos    <= pos_next;
      line   <= line_next;
      wlen   <= wlen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !end_of_text && wr_en) wbuf[wr_idx] <= char_byte;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n) q[wr + 2'(k)] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= 2'd0;
      wr    <= 2'd0;
      count <= 3'd0;
    end else begin
      if (pop) rd <= rd + 2'd1;
      if (accept) wr <= wr + n;
      count <= count + (accept ? {1'b0, n} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

endmodule

FILE: design/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the script token scanner
// output hold under stall and token field consistency
// ----------------------------------------------------------------------------
module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  token_kind,
  input logic [1:0]  error_code,
  input logic [15:0] token_length,
  input logic [15:0] line_number,
  input logic        last_of_run
);
  import sts_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(token_length))
    else $error("output word changed under stall");

  a_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_EOF |-> token_length == 16'd0 && last_of_run)
    else $error("eof word malformed");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> token_kind == K_ERROR)
    else $error("error code on non-error token");

  a_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 16'd0)
    else $error("line number zero");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty queue");

endmodule

bind script_token_scanner_core sts_checker u_sts_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .token_kind(token_kind),
  .error_code(error_code), .token_length(token_length),
  .line_number(line_number), .last_of_run(last_of_run)
);

FILE: sim/tb_script_token_scanner_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_script_token_scanner_core: self-checking bench for the token scanner
// feeds character words (directed, then random script-like text) through a
// bursty sender, predicts the tokens each word yields and checks every token
// field against the oldest prediction while the receiver stalls at random
// ----------------------------------------------------------------------------
module tb_script_token_scanner_core;
  import sts_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_byte;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  token_kind;
  logic [1:0]  error_code;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  script_token_scanner_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .char_byte(char_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .token_kind(token_kind), .error_code(error_code),
    .start_offset(start_offset), .token_length(token_length),
    .line_number(line_number), .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  word_t      pending_words[$];
  token_t     token_queue[$];
  int         errors = 0;
  int         tokens_seen = 0;
  int         words_sent = 0;
  bit         hold_sender = 1'b0;
  bit         long_hold_req = 1'b0;
  bit         long_hold_done;
  int         burst_left;
  int         gap_left;
  int         hold_left;

  // predictor state
  scan_mode_t pm_mode;
  logic [7:0] pm_op;
  logic [23:0] pm_start;
  logic [23:0] pm_pos;
  logic [15:0] pm_line;
  logic [7:0] pm_buf[8];
  logic [3:0] pm_wlen;
  token_t     step_out[$];

  function automatic logic [15:0] span_of(logic [23:0] a, logic [24:0] b);
    if (b < {1'b0, a}) return 16'd0;
    if (b - {1'b0, a} > 25'd65535) return 16'hffff;
    return 16'(b - {1'b0, a});
  endfunction

  task automatic push_tok(logic [5:0] k, logic [1:0] e, logic [23:0] s, logic [15:0] l);
    token_t t;
    t = '{kind: k, err: e, start: s, len: l, line: pm_line, last: 1'b0};
    if (step_out.size() < 4) step_out.push_back(t);
  endtask

  task automatic model_clear();
    pm_mode = M_IDLE;
    pm_op = 8'd0;
    pm_start = '0;
    pm_pos = '0;
    pm_line = 16'd1;
    pm_wlen = 4'd0;
    for (int i = 0; i < 8; i++) pm_buf[i] = 8'd0;
  endtask

  function automatic logic [5:0] keyword_kind();
    logic [5:0] kinds[16] = '{6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
                              6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37};
    string words[16] = '{"and", "class", "else", "false", "for", "function", "if", "null",
                         "or", "print", "return", "super", "this", "true", "var", "while"};
    bit hit;
    for (int i = 0; i < 16; i++) begin
      if (words[i].len() == pm_wlen) begin
        hit = 1'b1;
        for (int j = 0; j < words[i].len(); j++)
          if (pm_buf[j] != words[i][j]) hit = 1'b0;
        if (hit) return kinds[i];
      end
    end
    return K_IDENT;
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      "!": return K_BANG;
      "=": return K_EQUAL;
      ">": return K_GREATER;
      default: return K_LESS;
    endcase
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic begin_token(logic [7:0] c, logic [23:0] p);
    pm_mode = M_IDLE;
    pm_start = p;
    case (c)
      " ", 8'h0d, 8'h09: ;
      8'h0a: if (pm_line != 16'hffff) pm_line++;
      "(": push_tok(K_LPAREN, ERR_NONE, p, 16'd1);
      ")": push_tok(K_RPAREN, ERR_NONE, p, 16'd1);
      "{": push_tok(K_LBRACE, ERR_NONE, p, 16'd1);
      "}": push_tok(K_RBRACE, ERR_NONE, p, 16'd1);
      ",": push_tok(K_COMMA, ERR_NONE, p, 16'd1);
      ".": push_tok(K_DOT, ERR_NONE, p, 16'd1);
      "-": push_tok(K_MINUS, ERR_NONE, p, 16'd1);
      "+": push_tok(K_PLUS, ERR_NONE, p, 16'd1);
      ";": push_tok(K_SEMI, ERR_NONE, p, 16'd1);
      "*": push_tok(K_STAR, ERR_NONE, p, 16'd1);
      "/": pm_mode = M_SLASH;
      "!", "=", ">", "<": begin
        pm_op = c;
        pm_mode = M_OP2;
      end
      "\"", "'": pm_mode = M_STRING;
      default: begin
        if (alpha_ch(c)) begin
          pm_buf[0] = c;
          pm_wlen = 4'd1;
          pm_mode = M_IDENT;
        end else if (digit_ch(c)) begin
          pm_mode = M_NUMBER;
        end else begin
          push_tok(K_ERROR, ERR_UNEXPECTED, p, 16'd1);
        end
      end
    endcase
  endtask

  task automatic flush_token(logic [23:0] p);
    case (pm_mode)
      M_SLASH: push_tok(K_SLASH, ERR_NONE, pm_start, 16'd1);
      M_OP2: push_tok(op_kind(pm_op), ERR_NONE, pm_start, 16'd1);
      M_IDENT: push_tok(keyword_kind(), ERR_NONE, pm_start, span_of(pm_start, {1'b0, p}));
      M_NUMBER, M_FRACTION:
        push_tok(K_NUMBER, ERR_NONE, pm_start, span_of(pm_start, {1'b0, p}));
      M_NUMDOT: begin
        push_tok(K_NUMBER, ERR_NONE, pm_start, span_of(pm_start, {1'b0, p - 24'd1}));
        push_tok(K_DOT, ERR_NONE, p - 24'd1, 16'd1);
      end
      M_STRING: push_tok(K_ERROR, ERR_UNTERM, pm_start, span_of(pm_start, {1'b0, p}));
      default: ;
    endcase
    pm_mode = M_IDLE;
  endtask

  task automatic predict_tokens(word_t w);
    logic [7:0]  c;
    logic [23:0] p;
    c = w.ch;
    p = pm_pos;
    step_out.delete();
    if (w.eot) begin
      flush_token(p);
      push_tok(K_EOF, ERR_NONE, p, 16'd0);
      model_clear();
    end else begin
      case (pm_mode)
        M_SLASH:
          if (c == "/") pm_mode = M_COMMENT;
          else begin flush_token(p); begin_token(c, p); end
        M_COMMENT: if (c == 8'h0a) begin_token(c, p);
        M_OP2:
          if (c == "=") begin
            push_tok(op_kind(pm_op) + 6'd1, ERR_NONE, pm_start, 16'd2);
            pm_mode = M_IDLE;
          end else begin flush_token(p); begin_token(c, p); end
        M_IDENT:
          if (alpha_ch(c) || digit_ch(c)) begin
            if (pm_wlen < 4'd8) pm_buf[pm_wlen[2:0]] = c;
            if (pm_wlen < 4'd15) pm_wlen++;
          end else begin flush_token(p); begin_token(c, p); end
        M_NUMBER:
          if (c == ".") pm_mode = M_NUMDOT;
          else if (!digit_ch(c)) begin flush_token(p); begin_token(c, p); end
        M_NUMDOT:
          if (digit_ch(c)) pm_mode = M_FRACTION;
          else begin flush_token(p); begin_token(c, p); end
        M_FRACTION:
          if (!digit_ch(c)) begin flush_token(p); begin_token(c, p); end
        M_STRING:
          if (c == "\"" || c == "'") begin
            push_tok(K_STRING, ERR_NONE, pm_start, span_of(pm_start, {1'b0, p} + 25'd1));
            pm_mode = M_IDLE;
          end else if (c == 8'h0a) begin
            if (pm_line != 16'hffff) pm_line++;
          end
        default: begin_token(c, p);
      endcase
      if (pm_pos != 24'hffffff) pm_pos++;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) token_queue.push_back(step_out[i]);
  endtask

  // stimulus helpers
  task automatic add_char(logic [7:0] c);
    pending_words.push_back('{ch: c, eot: 1'b0});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_eot();
    pending_words.push_back('{ch: 8'($urandom), eot: 1'b1});
  endtask

  function automatic string rand_fragment();
    string frags[24] = '{"and ", "class", "else", "false", "for", "function ", "if", "null",
                         "or", "print", "return", "super", "this", "true", "var", "while",
                         "x1_y", "functions", "longidentifier_z9", "12.5", "7.", "3..",
                         "\"ab\nc'", "// note\n"};
    string ops[14] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "/", "!=", "<=", ">"};
    case ($urandom_range(0, 5))
      0, 1: return frags[$urandom_range(0, 23)];
      2: return ops[$urandom_range(0, 13)];
      3: return " ";
      4: return "\n";
      default: return "=";
    endcase
  endfunction

  // driver: bursts with gaps, optional pause
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      char_byte <= 8'd0;
      end_of_text <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_tokens('{ch: char_byte, eot: end_of_text});
        words_sent <= words_sent + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (hold_sender || pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        char_byte <= w.ch;
        end_of_text <= w.eot;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: random stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done && hold_left == 0) begin
      hold_left <= 200;
      long_hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (words_sent % 100 < 40) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      token_t e;
      tokens_seen++;
      if (token_queue.size() == 0) begin
        $error("unexpected token kind %0d", token_kind);
        errors++;
      end else begin
        e = token_queue.pop_front();
        if (token_kind !== e.kind) begin
          $error("token_kind exp %0d got %0d", e.kind, token_kind); errors++;
        end
        if (error_code !== e.err) begin
          $error("error_code exp %0d got %0d", e.err, error_code); errors++;
        end
        if (start_offset !== e.start) begin
          $error("start_offset exp %0d got %0d", e.start, start_offset); errors++;
        end
        if (token_length !== e.len) begin
          $error("token_length exp %0d got %0d", e.len, token_length); errors++;
        end
        if (line_number !== e.line) begin
          $error("line_number exp %0d got %0d", e.line, line_number); errors++;
        end
        if (last_of_run !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, last_of_run); errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("script_token_scanner_core: mismatch");
    $finish;
  end

  initial begin
    model_clear();
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: operators, keywords, number dot cases, errors, strings
    add_text("(){},.-+;*/!!====>>=<<=/x");
    add_eot();
    add_text("12.a 3.5 7..");
    add_char(8'h00);
    add_char(8'hff);
    add_char(8'h80);
    add_char("@");
    add_text("'it\n\"");
    add_eot();
    add_text("function functionx if or");
    add_eot();
    add_text("\"open");
    add_eot();
    add_text("9.");
    add_eot();
    add_eot();
    while (pending_words.size() > 0 || in_valid) @(posedge clk);

    // pause until drained
    hold_sender = 1'b1;
    while (token_queue.size() > 0) @(posedge clk);
    hold_sender = 1'b0;

    // long receiver hold while sender keeps offering
    long_hold_req = 1'b1;
    add_text("a.b.c.d.e.f.g.h.1.2.3.4.x;");

    // random: mostly well formed text, some raw bytes
    for (int n = 0; n < 260; ) begin
      if ($urandom_range(0, 9) == 0) begin
        add_char(8'($urandom));
        n++;
      end else if ($urandom_range(0, 40) == 0) begin
        add_eot();
        n++;
      end else begin
        string s;
        s = rand_fragment();
        add_text(s);
        n += s.len();
      end
    end
    add_eot();

    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (token_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d character words and %0d tokens, with bursts, stalls and a long hold",
             words_sent, tokens_seen);
    if (errors == 0 && token_queue.size() == 0)
      $display("script_token_scanner_core: match");
    else
      $display("script_token_scanner_core: mismatch");
    $finish;
  end

endmodule
